FILE: hw/rtl/crc_framed_packet_receiver_assert.svh
// Assertion macros shared by the receiver RTL.
// Each expects clk and rst_n in scope.
`ifndef CRC_FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define CRC_FRAMED_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define CRCPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CRCPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/crcpr_pkg.sv
package crcpr_pkg;

  localparam int BUF_DEPTH_DEF = 512;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 48;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REV = 16'h8408;  // 0x1021 bit-reversed
  localparam logic [7:0]  SYNC0        = 8'hFF;
  localparam logic [7:0]  SYNC1        = 8'h55;
  localparam logic [7:0]  RSND0        = 8'h00;
  localparam logic [7:0]  RSND1        = 8'hAA;
  localparam logic [9:0]  LEN_ADJ      = 10'd7;    // header, ID, length and CRC bytes, plus one for the payload

  localparam logic [15:0] RX_TIMEOUT_RST   = 16'd100;
  localparam logic [9:0]  BUFFER_LIMIT_RST = 10'd512;

  typedef enum logic [1:0] {
    FN_BYTE    = 2'd0,
    FN_TICK    = 2'd1,
    FN_READ    = 2'd2,
    FN_RELEASE = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RX_TIMEOUT   = 2'd0,
    CFG_BUFFER_LIMIT = 2'd1,
    CFG_ID_CHECK     = 2'd2,
    CFG_RESEND       = 2'd3
  } cfg_idx_t;

  // Reflected CRC16 update, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REV;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/crcpr_ram.sv
module crcpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/crc_framed_packet_receiver.sv
// After its input item is accepted, a result item passes through stage s1, which waits
// on the frame store read, and then the output register. Throughput: one item per cycle
// unless the output stalls; each item makes at most one frame store write or read.
// Reset: rst_n is synchronous, active low; it clears control state and counters and
// loads configuration defaults. The frame store is not cleared.
module crc_framed_packet_receiver #(
  parameter int BUF_DEPTH = crcpr_pkg::BUF_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // cfg port: write only
  input  logic                              cfg_we,
  input  logic [crcpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crcpr_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input item
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [crcpr_pkg::IN_DATA_W-1:0]   in_tdata,   // rx_byte[7:0], read_index[15:8]
  input  logic [1:0]                        in_tuser,   // func[1:0]
  // result item
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // rx_status[2:0], payload_length[11:3], frame_id[19:12], read_data[27:20],
  // error_count[43:28], nak_request[44], retransmit_request[45], zero[47:46]
  output logic [crcpr_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import crcpr_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  // wide enough for the limit, the position and BUF_DEPTH itself
  localparam int LW = (AW + 1 > 10) ? AW + 1 : 10;
  // wide enough for read_index + 4 and a store address
  localparam int RW = (AW > 9) ? AW : 9;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_RECV = 3'd1,
    M_RSP  = 3'd2,
    M_RSH  = 3'd3,
    M_ERR  = 3'd4,
    M_DONE = 3'd5
  } mode_t;

  // Configuration
  logic [15:0] tmo_r;
  logic [9:0]  blim_r;
  logic        idchk_r;
  logic        rsnd_r;

  // Receiver state
  mode_t       mode_r,    mode_nxt;
  logic [15:0] crc_r,     crc_nxt;
  logic [9:0]  bp_r,      bp_nxt;
  logic [9:0]  ft_r,      ft_nxt;
  logic [7:0]  last_id_r, last_id_nxt;
  logic [7:0]  id_r,      id_nxt;     // copy of stored byte 2
  logic [7:0]  len_r,     len_nxt;    // copy of stored byte 3
  logic [15:0] tl_r,      tl_nxt;
  logic [15:0] errc_r,    errc_nxt;

  // Pipeline: s1 waits on the store read, out_r holds the result
  logic        s1_v_r;
  logic        s1_rd_ok_r;
  logic [2:0]  s1_status_r;
  logic [8:0]  s1_plen_r;
  logic [7:0]  s1_fid_r;
  logic [15:0] s1_errc_r;
  logic        s1_nak_r;
  logic        s1_rtx_r;
  logic        out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic        s1_adv;

  // Item decode
  logic        acc;
  func_t       func;
  logic [7:0]  c;
  logic [7:0]  ri;
  logic [LW-1:0] lim;
  logic [LW-1:0] p_ext;
  logic [15:0] crc_new;
  logic [RW-1:0] rd_addr;
  logic        rd_ok;
  logic        nak;
  logic        rtx;
  mode_t       close_mode;

  // Store ports
  logic          st_we;
  logic          st_re;
  logic [AW-1:0] st_waddr;
  logic [AW-1:0] st_raddr;
  logic [7:0]    st_rdata;

  assign acc  = in_tvalid && in_tready;
  assign func = func_t'(in_tuser);
  assign c    = in_tdata[7:0];
  assign ri   = in_tdata[15:8];

  // Effective frame limit: smaller of the register and the store depth
  assign lim   = (LW'(blim_r) < LW'(BUF_DEPTH)) ? LW'(blim_r) : LW'(BUF_DEPTH);
  assign p_ext = LW'(bp_r);

  // Restart the CRC on the first byte of a frame
  assign crc_new = crc16_byte((bp_r == '0) ? CRC_INIT : crc_r, c);

  // Payload reads start past the four header bytes
  assign rd_addr = RW'(ri) + RW'(4);
  assign rd_ok   = (32'(rd_addr) < 32'(BUF_DEPTH));

  assign st_waddr = AW'(p_ext);
  assign st_raddr = AW'(rd_addr);

  always_comb begin
    mode_nxt    = mode_r;
    crc_nxt     = crc_r;
    bp_nxt      = bp_r;
    ft_nxt      = ft_r;
    last_id_nxt = last_id_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    tl_nxt      = tl_r;
    errc_nxt    = errc_r;
    nak         = 1'b0;
    rtx         = 1'b0;
    st_we       = 1'b0;
    st_re       = 1'b0;
    close_mode  = mode_r;

    if (acc) begin
      unique case (func)
        FN_BYTE: begin
          // drop bytes while a frame is closed and waiting
          if (mode_r != M_ERR && mode_r != M_DONE) begin
            tl_nxt = tmo_r;
            if (p_ext >= lim) begin
              mode_nxt = M_ERR;
            end else begin
              st_we   = 1'b1;
              crc_nxt = crc_new;
              priority if (bp_r == 10'd0) begin
                if (c == RSND0 && rsnd_r) begin
                  mode_nxt = M_RSP;
                end else if (c != SYNC0) begin
                  mode_nxt = M_ERR;
                end else begin
                  mode_nxt = M_RECV;
                end
              end else if (bp_r == 10'd1) begin
                if (mode_r == M_RSP) begin
                  mode_nxt = (c == RSND1) ? M_RSH : M_ERR;
                end else if (c != SYNC1) begin
                  mode_nxt = M_ERR;
                end
              end else if (bp_r == 10'd2) begin
                id_nxt = c;
                if (mode_r == M_RSP || mode_r == M_RSH) begin
                  mode_nxt = M_ERR;
                end
              end else if (bp_r == 10'd3) begin
                len_nxt = c;
                ft_nxt  = 10'(c) + LEN_ADJ;
                if (LW'(ft_nxt) > lim) begin
                  mode_nxt = M_ERR;
                end
              end else if (10'(bp_r + 10'd1) == ft_r) begin
                // last byte: remainder must be zero
                if (crc_new != 16'h0000) begin
                  mode_nxt = M_ERR;
                end else begin
                  mode_nxt    = (idchk_r && last_id_r == id_r) ? M_ERR : M_DONE;
                  last_id_nxt = id_r;
                end
              end
            end
            if (bp_r != 10'h3FF) begin
              bp_nxt = bp_r + 10'd1;
            end
          end
        end
        FN_TICK: begin
          if (bp_r != '0) begin
            if (tl_r <= 16'd1) begin
              // timeout closes the frame; a short count is an error
              if (ft_r != '0 && bp_r != ft_r) begin
                close_mode = M_ERR;
              end
              if (close_mode == M_RSH) begin
                rtx = 1'b1;
              end else if (close_mode == M_ERR) begin
                nak      = rsnd_r;
                errc_nxt = errc_r + 16'd1;
              end
              mode_nxt = M_IDLE;
              tl_nxt   = '0;
              bp_nxt   = '0;
              ft_nxt   = '0;
            end else begin
              tl_nxt = tl_r - 16'd1;
            end
          end
        end
        FN_READ: begin
          st_re = rd_ok;
        end
        FN_RELEASE: begin
          if (mode_r == M_DONE) begin
            mode_nxt = M_IDLE;
            bp_nxt   = '0;
            ft_nxt   = '0;
            tl_nxt   = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold s1 while the output register is stalled
  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r      <= RX_TIMEOUT_RST;
      blim_r     <= BUFFER_LIMIT_RST;
      idchk_r    <= 1'b1;
      rsnd_r     <= 1'b1;
      mode_r     <= M_IDLE;
      crc_r      <= CRC_INIT;
      bp_r       <= '0;
      ft_r       <= '0;
      last_id_r  <= '0;
      tl_r       <= '0;
      errc_r     <= '0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_RX_TIMEOUT:   tmo_r   <= cfg_data[15:0];
          CFG_BUFFER_LIMIT: blim_r  <= cfg_data[9:0];
          CFG_ID_CHECK:     idchk_r <= cfg_data[0];
          CFG_RESEND:       rsnd_r  <= cfg_data[0];
          default: ;
        endcase
      end
      mode_r    <= mode_nxt;
      crc_r     <= crc_nxt;
      bp_r      <= bp_nxt;
      ft_r      <= ft_nxt;
      last_id_r <= last_id_nxt;
      tl_r      <= tl_nxt;
      errc_r    <= errc_nxt;
      if (in_tready) begin
        s1_v_r <= acc;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
    end

    // payload registers, no reset
    id_r  <= id_nxt;
    len_r <= len_nxt;
    if (acc) begin
      s1_rd_ok_r  <= (func == FN_READ) && rd_ok;
      s1_status_r <= mode_nxt;
      s1_plen_r   <= (mode_nxt == M_DONE) ? ({1'b0, len_nxt} + 9'd1) : '0;
      s1_fid_r    <= (mode_nxt == M_DONE) ? id_nxt : '0;
      s1_errc_r   <= errc_nxt;
      s1_nak_r    <= nak;
      s1_rtx_r    <= rtx;
    end
    if (s1_adv && s1_v_r) begin
      out_data_r <= {2'b00, s1_rtx_r, s1_nak_r, s1_errc_r,
                     (s1_rd_ok_r ? st_rdata : 8'h00),
                     s1_fid_r, s1_plen_r, s1_status_r};
    end
  end

  crcpr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (c),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

`include "crc_framed_packet_receiver_assert.svh"

  `CRCPR_ASSERT_IMP(a_done_count, mode_r == M_DONE, bp_r == ft_r, "done frame count mismatch")
  `CRCPR_ASSERT_IMP(a_idle_empty, mode_r == M_IDLE, bp_r == '0 && ft_r == '0, "idle with open frame")
  `CRCPR_ASSERT_NXT(a_errc_tick, !(acc && func == FN_TICK), $stable(errc_r), "error count moved without tick")
  `CRCPR_ASSERT_NXT(a_s1_hold, s1_v_r && !s1_adv,
                    s1_v_r && $stable(s1_status_r) && (!s1_rd_ok_r || $stable(st_rdata)),
                    "stalled stage lost")

endmodule
